>>> design/point_in_polygon_test_unit_defines.svh
// assertion macros for the point-in-polygon test unit
// no dependencies; taken in by the top level only
`ifndef POINT_IN_POLYGON_TEST_UNIT_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pip_pkg.sv
// shared types, constants and orientation helpers for the point-in-polygon unit
// no dependencies
`timescale 1ns / 1ps

package pip_pkg;

    localparam int COORD_BITS   = 12;
    localparam int RAY_END_X    = 10000;
    localparam int MIN_VERTICES = 3;

    // ray end must exceed every coordinate; signed width holds values and differences
    localparam int RAY_BITS = $clog2(RAY_END_X + 1);
    localparam int DIFF_W   = RAY_BITS + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int CNT_W    = $clog2(MIN_VERTICES + 1);

    typedef logic [COORD_BITS-1:0]   t_coord;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic [CNT_W-1:0]        t_count;

    typedef enum logic [1:0] {
        TURN_COLLINEAR,
        TURN_CW,
        TURN_CCW
    } t_turn;

    typedef struct packed {
        t_coord vertex_x;
        t_coord vertex_y;
        t_coord point_x;
        t_coord point_y;
        logic   last_vertex;
    } t_vertex;

    typedef struct packed {
        logic inside_res;
        logic decided_on_edge;
        logic too_few_vertices;
    } t_result;

    // outcome of one edge against the ray
    typedef struct packed {
        logic crosses;
        logic on_line;
        logic in_box;
    } t_edge_hit;

    function automatic t_diff widen(input t_coord c);
        return t_diff'(c);
    endfunction

    // orientation of the triple a, b, c from the sign of the cross product
    function automatic t_turn turn_of(input t_diff ax, input t_diff ay,
                                      input t_diff bx, input t_diff by,
                                      input t_diff cx, input t_diff cy);
        t_diff d1, d2, d3, d4;
        logic signed [PROD_W-1:0]  p1, p2;
        logic signed [CROSS_W-1:0] v;
        d1 = by - ay;
        d2 = cx - bx;
        d3 = bx - ax;
        d4 = cy - by;
        p1 = PROD_W'(d1) * PROD_W'(d2);
        p2 = PROD_W'(d3) * PROD_W'(d4);
        v  = CROSS_W'(p1) - CROSS_W'(p2);
        if (v == '0) begin
            return TURN_COLLINEAR;
        end else if (v > 0) begin
            return TURN_CW;
        end else begin
            return TURN_CCW;
        end
    endfunction

    // orientation of ray start, ray end, vertex: the ray is horizontal and
    // its end lies right of every point, so only the y order matters
    function automatic t_turn ray_turn(input t_diff vy, input t_diff py);
        if (vy == py) begin
            return TURN_COLLINEAR;
        end else if (vy < py) begin
            return TURN_CW;
        end else begin
            return TURN_CCW;
        end
    endfunction

    // is b within the bounding box of a and c
    function automatic logic in_box(input t_diff ax, input t_diff ay,
                                    input t_diff bx, input t_diff by,
                                    input t_diff cx, input t_diff cy);
        t_diff lox, hix, loy, hiy;
        lox = (ax < cx) ? ax : cx;
        hix = (ax < cx) ? cx : ax;
        loy = (ay < cy) ? ay : cy;
        hiy = (ay < cy) ? cy : ay;
        return (bx >= lox) && (bx <= hix) && (by >= loy) && (by <= hiy);
    endfunction

endpackage

>>> design/pip_ifaces.sv
// valid/ready channel interfaces for vertex items and results
// depends on pip_pkg
`timescale 1ns / 1ps

interface pip_vertex_if
    import pip_pkg::*;
;
    logic   valid;
    logic   ready;
    t_coord vertex_x;
    t_coord vertex_y;
    t_coord point_x;
    t_coord point_y;
    logic   last_vertex;

    modport source (output valid, vertex_x, vertex_y, point_x, point_y, last_vertex,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, point_x, point_y, last_vertex,
                    output ready);
endinterface

interface pip_result_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic decided_on_edge;
    logic too_few_vertices;

    modport source (output valid, inside_res, decided_on_edge, too_few_vertices,
                    input ready);
    modport sink   (input valid, inside_res, decided_on_edge, too_few_vertices,
                    output ready);
endinterface

>>> design/pip_edge_test.sv
// one polygon edge against the horizontal ray from the query point
// depends on pip_pkg
`timescale 1ns / 1ps

module pip_edge_test
    import pip_pkg::*;
(
    input  t_coord    i_ax,
    input  t_coord    i_ay,
    input  t_coord    i_bx,
    input  t_coord    i_by,
    input  t_coord    i_px,
    input  t_coord    i_py,
    output t_edge_hit o_hit
);

    t_diff w_ax, w_ay, w_bx, w_by, w_px, w_py, w_rx;
    t_turn w_o1, w_o2, w_o3, w_o4;
    logic  w_box_apb, w_box_arb, w_box_par, w_box_pbr;

    assign w_ax = widen(i_ax);
    assign w_ay = widen(i_ay);
    assign w_bx = widen(i_bx);
    assign w_by = widen(i_by);
    assign w_px = widen(i_px);
    assign w_py = widen(i_py);
    assign w_rx = t_diff'(RAY_END_X);

    // four orientations of the segment pair, two of them reduce to y compares
    assign w_o1 = turn_of(w_ax, w_ay, w_bx, w_by, w_px, w_py);
    assign w_o2 = turn_of(w_ax, w_ay, w_bx, w_by, w_rx, w_py);
    assign w_o3 = ray_turn(w_ay, w_py);
    assign w_o4 = ray_turn(w_by, w_py);

    // on-segment checks for the collinear cases
    assign w_box_apb = in_box(w_ax, w_ay, w_px, w_py, w_bx, w_by);
    assign w_box_arb = in_box(w_ax, w_ay, w_rx, w_py, w_bx, w_by);
    assign w_box_par = in_box(w_px, w_py, w_ax, w_ay, w_rx, w_py);
    assign w_box_pbr = in_box(w_px, w_py, w_bx, w_by, w_rx, w_py);

    always_comb begin
        o_hit.crosses = ((w_o1 != w_o2) && (w_o3 != w_o4))
                     || ((w_o1 == TURN_COLLINEAR) && w_box_apb)
                     || ((w_o2 == TURN_COLLINEAR) && w_box_arb)
                     || ((w_o3 == TURN_COLLINEAR) && w_box_par)
                     || ((w_o4 == TURN_COLLINEAR) && w_box_pbr);
        // point collinear with the edge: same zero test as a, p, b
        o_hit.on_line = (w_o1 == TURN_COLLINEAR);
        o_hit.in_box  = w_box_apb;
    end

endmodule

>>> design/pip_poly_state.sv
// per-polygon state: latched point and vertices, count, parity and edge decision
// depends on pip_pkg and pip_edge_test
`timescale 1ns / 1ps

module pip_poly_state
    import pip_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_vertex i_item,
    output t_result o_result
);

    t_coord r_first_x, r_first_y, r_prev_x, r_prev_y, r_query_x, r_query_y;
    t_coord n_first_x, n_first_y, n_query_x, n_query_y;
    t_count r_count, n_count;
    logic   r_parity, r_decided, r_answer;
    logic   n_parity, n_decided, n_answer;

    t_edge_hit w_hit_prev, w_hit_close;
    logic      w_too_few, w_test_prev;
    logic      w_par1, w_dec1, w_ans1, w_par2, w_dec2, w_ans2;

    // edge from the previous vertex to this one
    pip_edge_test u_edge_prev (
        .i_ax  (r_prev_x),
        .i_ay  (r_prev_y),
        .i_bx  (i_item.vertex_x),
        .i_by  (i_item.vertex_y),
        .i_px  (r_query_x),
        .i_py  (r_query_y),
        .o_hit (w_hit_prev)
    );

    // closing edge from this vertex back to the first
    pip_edge_test u_edge_close (
        .i_ax  (i_item.vertex_x),
        .i_ay  (i_item.vertex_y),
        .i_bx  (r_first_x),
        .i_by  (r_first_y),
        .i_px  (r_query_x),
        .i_py  (r_query_y),
        .o_hit (w_hit_close)
    );

    assign w_too_few   = i_item.last_vertex && (r_count < t_count'(MIN_VERTICES - 1));
    assign w_test_prev = (r_count != '0) && !w_too_few;

    // fold the outcomes of both edge tests into parity and decision
    always_comb begin
        w_par1 = r_parity;
        w_dec1 = r_decided;
        w_ans1 = r_answer;
        if (w_test_prev && !r_decided && w_hit_prev.crosses) begin
            if (w_hit_prev.on_line) begin
                w_dec1 = 1'b1;
                w_ans1 = w_hit_prev.in_box;
            end else begin
                w_par1 = ~r_parity;
            end
        end
        w_par2 = w_par1;
        w_dec2 = w_dec1;
        w_ans2 = w_ans1;
        if (!w_dec1 && w_hit_close.crosses) begin
            if (w_hit_close.on_line) begin
                w_dec2 = 1'b1;
                w_ans2 = w_hit_close.in_box;
            end else begin
                w_par2 = ~w_par1;
            end
        end
    end

    // result of a last vertex
    always_comb begin
        if (w_too_few) begin
            o_result.inside_res       = 1'b0;
            o_result.decided_on_edge  = 1'b0;
            o_result.too_few_vertices = 1'b1;
        end else begin
            o_result.inside_res       = w_dec2 ? w_ans2 : w_par2;
            o_result.decided_on_edge  = w_dec2;
            o_result.too_few_vertices = 1'b0;
        end
    end

    // next state for the polygon
    always_comb begin
        n_first_x = r_first_x;
        n_first_y = r_first_y;
        n_query_x = r_query_x;
        n_query_y = r_query_y;
        if (r_count == '0) begin
            n_first_x = i_item.vertex_x;
            n_first_y = i_item.vertex_y;
            n_query_x = i_item.point_x;
            n_query_y = i_item.point_y;
        end
        if (i_item.last_vertex) begin
            n_count   = '0;
            n_parity  = 1'b0;
            n_decided = 1'b0;
            n_answer  = 1'b0;
        end else begin
            n_count   = (r_count == t_count'(MIN_VERTICES)) ? r_count : r_count + 1'b1;
            n_parity  = w_par1;
            n_decided = w_dec1;
            n_answer  = w_ans1;
        end
    end

    // coordinate registers
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_first_x <= n_first_x;
            r_first_y <= n_first_y;
            r_query_x <= n_query_x;
            r_query_y <= n_query_y;
            r_prev_x  <= i_item.vertex_x;
            r_prev_y  <= i_item.vertex_y;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_parity  <= 1'b0;
            r_decided <= 1'b0;
            r_answer  <= 1'b0;
        end else if (i_fire) begin
            r_count   <= n_count;
            r_parity  <= n_parity;
            r_decided <= n_decided;
            r_answer  <= n_answer;
        end
    end

endmodule

>>> design/point_in_polygon_test_unit.sv
// top level of the streaming point-in-polygon test
// depends on pip_pkg, pip_ifaces, pip_poly_state and the defines header
//
//  channel  | dir | payload                                            | transaction
//  ---------+-----+----------------------------------------------------+-----------------
//  i_vtx    | in  | vertex_x, vertex_y, point_x, point_y, last_vertex  | one vertex
//  o_res    | out | inside_res, decided_on_edge, too_few_vertices      | one polygon result
//
// one vertex per cycle unless a last vertex waits for room in the result register:
// input register, then both edge tests and the state update in one pass, then
// the result register.
// synchronous active-low reset clears the valid flags and polygon counters.
// a stalled result holds only vertices marked last; others keep flowing.
`timescale 1ns / 1ps
`include "point_in_polygon_test_unit_defines.svh"

module point_in_polygon_test_unit
    import pip_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pip_vertex_if.sink    i_vtx,
    pip_result_if.source  o_res
);

    logic    r_in_valid, r_out_valid;
    t_vertex r_in;
    t_result r_out, w_result;
    logic    w_out_free, w_fire, w_in_take;

    // a last vertex needs room in the result register
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_fire     = r_in_valid && (!r_in.last_vertex || w_out_free);
    assign i_vtx.ready = !r_in_valid || w_fire;
    assign w_in_take   = i_vtx.valid && i_vtx.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.vertex_x    <= i_vtx.vertex_x;
            r_in.vertex_y    <= i_vtx.vertex_y;
            r_in.point_x     <= i_vtx.point_x;
            r_in.point_y     <= i_vtx.point_y;
            r_in.last_vertex <= i_vtx.last_vertex;
        end
    end

    pip_poly_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in.last_vertex) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in.last_vertex) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.inside_res       = r_out.inside_res;
    assign o_res.decided_on_edge  = r_out.decided_on_edge;
    assign o_res.too_few_vertices = r_out.too_few_vertices;

    // checks
    `PIP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_fire && r_in.last_vertex, r_out_valid, "last vertex produced no result")
    `PIP_ASSERT_IMP(a_result_from_last, i_clk, i_rst_n, $rose(r_out_valid), $past(w_fire && r_in.last_vertex), "result without a last vertex")
    `PIP_ASSERT_IMP(a_too_few_clean, i_clk, i_rst_n, r_out_valid && r_out.too_few_vertices, !r_out.inside_res && !r_out.decided_on_edge, "too-few result carries an answer")

endmodule

>>> verif/point_in_polygon_test_unit_tb.sv
// self-checking testbench for the streaming point-in-polygon test unit
// depends on pip_pkg, pip_ifaces and the point_in_polygon_test_unit top level
`timescale 1ns / 1ps

module point_in_polygon_test_unit_tb;
    import pip_pkg::*;

    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int SETTLE_CYCLES = 16;
    localparam int TIMEOUT_NS    = 4_000_000;

    typedef enum int {
        SHAPE_WIDE,
        SHAPE_GRID,
        SHAPE_CORNER,
        SHAPE_SHORT,
        SHAPE_LONG
    } t_shape;

    // one row of the directed table; verdict is used only when typed is set
    typedef struct {
        t_vertex item;
        bit      typed;
        t_result verdict;
    } t_vertex_row;

    logic i_clk;
    logic i_rst_n;

    pip_vertex_if vtx_ch ();
    pip_result_if res_ch ();

    point_in_polygon_test_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_ch),
        .o_res   (res_ch)
    );

    // polygon tracker state
    t_coord  trk_first_x, trk_first_y;
    t_coord  trk_prev_x, trk_prev_y;
    t_coord  trk_query_x, trk_query_y;
    t_count  trk_count;
    bit      trk_parity, trk_decided, trk_answer;

    t_result     pending_verdicts[$];
    t_vertex_row directed_rows[$];
    int          mismatch_count;
    int          burst_left;

    // orientation of the triple a, b, c
    function automatic t_turn orient(input longint ax, input longint ay,
                                     input longint bx, input longint by,
                                     input longint cx, input longint cy);
        longint v;
        v = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
        if (v == 0) begin
            return TURN_COLLINEAR;
        end
        return (v > 0) ? TURN_CW : TURN_CCW;
    endfunction

    // b lies within the box spanned by a and c
    function automatic bit box_holds(input longint ax, input longint ay,
                                     input longint bx, input longint by,
                                     input longint cx, input longint cy);
        longint lox, hix, loy, hiy;
        lox = (ax < cx) ? ax : cx;
        hix = (ax < cx) ? cx : ax;
        loy = (ay < cy) ? ay : cy;
        hiy = (ay < cy) ? cy : ay;
        return (bx >= lox) && (bx <= hix) && (by >= loy) && (by <= hiy);
    endfunction

    function automatic bit segments_meet(input longint p1x, input longint p1y,
                                         input longint q1x, input longint q1y,
                                         input longint p2x, input longint p2y,
                                         input longint q2x, input longint q2y);
        t_turn o1, o2, o3, o4;
        o1 = orient(p1x, p1y, q1x, q1y, p2x, p2y);
        o2 = orient(p1x, p1y, q1x, q1y, q2x, q2y);
        o3 = orient(p2x, p2y, q2x, q2y, p1x, p1y);
        o4 = orient(p2x, p2y, q2x, q2y, q1x, q1y);
        if (o1 != o2 && o3 != o4) return 1'b1;
        if (o1 == TURN_COLLINEAR && box_holds(p1x, p1y, p2x, p2y, q1x, q1y)) return 1'b1;
        if (o2 == TURN_COLLINEAR && box_holds(p1x, p1y, q2x, q2y, q1x, q1y)) return 1'b1;
        if (o3 == TURN_COLLINEAR && box_holds(p2x, p2y, p1x, p1y, q2x, q2y)) return 1'b1;
        if (o4 == TURN_COLLINEAR && box_holds(p2x, p2y, q1x, q1y, q2x, q2y)) return 1'b1;
        return 1'b0;
    endfunction

    // one polygon edge against the ray from the query point
    function automatic void cast_edge(input longint ax, input longint ay,
                                      input longint bx, input longint by);
        longint px, py;
        px = trk_query_x;
        py = trk_query_y;
        if (trk_decided) return;
        if (!segments_meet(ax, ay, bx, by, px, py, RAY_END_X, py)) return;
        if (orient(ax, ay, px, py, bx, by) == TURN_COLLINEAR) begin
            trk_decided = 1'b1;
            trk_answer  = box_holds(ax, ay, px, py, bx, by);
            return;
        end
        trk_parity = ~trk_parity;
    endfunction

    // advance the tracker by one vertex; a verdict comes with the last one
    function automatic void advance_polygon(input t_vertex v, output bit has_verdict,
                                            output t_result verdict);
        t_count total;
        if (trk_count == 0) begin
            trk_query_x = v.point_x;
            trk_query_y = v.point_y;
            trk_first_x = v.vertex_x;
            trk_first_y = v.vertex_y;
        end
        total = (trk_count < MIN_VERTICES) ? t_count'(trk_count + 1) : t_count'(MIN_VERTICES);
        has_verdict = v.last_vertex;
        verdict     = '0;
        if (v.last_vertex && total < MIN_VERTICES) begin
            verdict.too_few_vertices = 1'b1;
        end else begin
            if (trk_count != 0) cast_edge(trk_prev_x, trk_prev_y, v.vertex_x, v.vertex_y);
            if (v.last_vertex) begin
                cast_edge(v.vertex_x, v.vertex_y, trk_first_x, trk_first_y);
                verdict.inside_res      = trk_decided ? trk_answer : trk_parity;
                verdict.decided_on_edge = trk_decided;
            end
        end
        trk_prev_x = v.vertex_x;
        trk_prev_y = v.vertex_y;
        if (v.last_vertex) begin
            trk_count   = '0;
            trk_parity  = 1'b0;
            trk_decided = 1'b0;
            trk_answer  = 1'b0;
        end else begin
            trk_count = total;
        end
    endfunction

    function automatic void add_row(input int vx, input int vy, input int px, input int py,
                                    input bit last, input bit typed, input bit in_poly,
                                    input bit on_edge, input bit few);
        t_vertex_row r;
        r.item.vertex_x               = t_coord'(vx);
        r.item.vertex_y               = t_coord'(vy);
        r.item.point_x                = t_coord'(px);
        r.item.point_y                = t_coord'(py);
        r.item.last_vertex            = last;
        r.typed                       = typed;
        r.verdict.inside_res          = in_poly;
        r.verdict.decided_on_edge     = on_edge;
        r.verdict.too_few_vertices    = few;
        directed_rows = {directed_rows, r};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] error: %s", $time, msg);
        mismatch_count++;
    endtask

    // drive one vertex, with bursts and gaps, and log its verdict on acceptance
    task automatic send_vertex(input t_vertex v, input bit typed, input t_result typed_verdict);
        bit      has_verdict;
        t_result verdict;
        int      gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                vtx_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        vtx_ch.valid       <= 1'b1;
        vtx_ch.vertex_x    <= v.vertex_x;
        vtx_ch.vertex_y    <= v.vertex_y;
        vtx_ch.point_x     <= v.point_x;
        vtx_ch.point_y     <= v.point_y;
        vtx_ch.last_vertex <= v.last_vertex;
        do @(posedge i_clk); while (vtx_ch.ready !== 1'b1);
        advance_polygon(v, has_verdict, verdict);
        if (has_verdict) begin
            pending_verdicts = {pending_verdicts, (typed ? typed_verdict : verdict)};
        end
    endtask

    // hold the sender until every pending verdict has come back
    task automatic drain_verdicts();
        vtx_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_coord pick_coord(input t_shape shape, input int base);
        case (shape)
            SHAPE_GRID:   return t_coord'(base + $urandom_range(0, 7));
            SHAPE_CORNER: return ($urandom_range(0, 1) != 0) ? t_coord'(COORD_MAX) : '0;
            default:      return t_coord'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("point_in_polygon_test_unit: mismatch");
        $finish;
    end

    // receiver stall pattern: free runs, random stalls and long holds
    initial begin
        int mode, span;
        res_ch.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 60);
            for (int i = 0; i < span; i++) begin
                @(posedge i_clk);
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 1) != 0);
                    2:       res_ch.ready <= (i == span - 1);
                    default: res_ch.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result transaction with no verdict pending");
            end else begin
                want = pending_verdicts.pop_front();
                if (res_ch.inside_res !== want.inside_res)
                    report_mismatch($sformatf("inside_res got %b want %b",
                                              res_ch.inside_res, want.inside_res));
                if (res_ch.decided_on_edge !== want.decided_on_edge)
                    report_mismatch($sformatf("decided_on_edge got %b want %b",
                                              res_ch.decided_on_edge, want.decided_on_edge));
                if (res_ch.too_few_vertices !== want.too_few_vertices)
                    report_mismatch($sformatf("too_few_vertices got %b want %b",
                                              res_ch.too_few_vertices, want.too_few_vertices));
            end
        end
    end

    // stimulus
    initial begin
        t_vertex v;
        t_shape  shape;
        int      sel, nverts, sent, base_x, base_y;

        mismatch_count = 0;
        burst_left     = 0;
        trk_first_x = '0; trk_first_y = '0;
        trk_prev_x  = '0; trk_prev_y  = '0;
        trk_query_x = '0; trk_query_y = '0;
        trk_count   = '0;
        trk_parity  = 1'b0; trk_decided = 1'b0; trk_answer = 1'b0;

        vtx_ch.valid       <= 1'b0;
        vtx_ch.vertex_x    <= '0;
        vtx_ch.vertex_y    <= '0;
        vtx_ch.point_x     <= '0;
        vtx_ch.point_y     <= '0;
        vtx_ch.last_vertex <= 1'b0;
        i_rst_n            <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-vertex polygons at both corners of the range
        add_row(0, 0, 0, 0, 1, 1, 0, 0, 1);
        add_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 0, 0, 1);
        // two vertices only
        add_row(COORD_MAX, 0, COORD_MAX, 0, 0, 0, 0, 0, 0);
        add_row(0, COORD_MAX, 0, COORD_MAX, 1, 1, 0, 0, 1);
        // full square, point strictly inside; later point fields are ignored
        add_row(0, 0, 2000, 2000, 0, 0, 0, 0, 0);
        add_row(COORD_MAX, 0, 123, 456, 0, 0, 0, 0, 0);
        add_row(COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, COORD_MAX, COORD_MAX, COORD_MAX, 1, 0, 0, 0, 0);
        // full square, point on the right edge
        add_row(0, 0, COORD_MAX, 2000, 0, 0, 0, 0, 0);
        add_row(COORD_MAX, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, COORD_MAX, 0, 0, 1, 0, 0, 0, 0);
        // triangle whose base lies on the ray right of the point
        add_row(3000, 1000, 1000, 1000, 0, 0, 0, 0, 0);
        add_row(4000, 1000, 0, 0, 0, 0, 0, 0, 0);
        add_row(3500, 3000, 0, 0, 1, 0, 0, 0, 0);
        // pentagon with the point on a vertex, count saturates
        add_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0);
        add_row(2000, COORD_MAX, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 2000, 0, 0, 0, 0, 0, 0, 0);
        add_row(2000, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(COORD_MAX, 2000, 0, 0, 1, 0, 0, 0, 0);
        // point far from a small triangle
        add_row(100, 100, 0, COORD_MAX, 0, 0, 0, 0, 0);
        add_row(200, 100, 0, 0, 0, 0, 0, 0, 0);
        add_row(150, 200, 0, 0, 1, 0, 0, 0, 0);

        foreach (directed_rows[i]) begin
            send_vertex(directed_rows[i].item, directed_rows[i].typed,
                        directed_rows[i].verdict);
        end
        drain_verdicts();

        // random polygons, mostly well-formed with random content
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 40)      shape = SHAPE_WIDE;
            else if (sel < 70) shape = SHAPE_GRID;
            else if (sel < 80) shape = SHAPE_CORNER;
            else if (sel < 90) shape = SHAPE_SHORT;
            else               shape = SHAPE_LONG;
            case (shape)
                SHAPE_SHORT: nverts = $urandom_range(1, 2);
                SHAPE_LONG:  nverts = $urandom_range(8, 14);
                default:     nverts = $urandom_range(3, 7);
            endcase
            base_x = $urandom_range(0, COORD_MAX - 7);
            base_y = $urandom_range(0, COORD_MAX - 7);
            if ($urandom_range(0, 24) == 0) drain_verdicts();
            for (int k = 0; k < nverts; k++) begin
                v.vertex_x = pick_coord(shape, base_x);
                v.vertex_y = pick_coord(shape, base_y);
                if (k == 0 && shape == SHAPE_GRID) begin
                    v.point_x = pick_coord(shape, base_x);
                    v.point_y = pick_coord(shape, base_y);
                end else if (k == 0 && shape == SHAPE_CORNER) begin
                    v.point_x = t_coord'($urandom_range(0, 2) * (COORD_MAX / 2));
                    v.point_y = t_coord'($urandom_range(0, 2) * (COORD_MAX / 2));
                end else begin
                    v.point_x = t_coord'($urandom_range(0, COORD_MAX));
                    v.point_y = t_coord'($urandom_range(0, COORD_MAX));
                end
                v.last_vertex = (k == nverts - 1);
                send_vertex(v, 1'b0, '0);
                sent++;
            end
        end

        // wait for the tail, then settle
        vtx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("point_in_polygon_test_unit: match");
        end else begin
            $display("point_in_polygon_test_unit: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/pip_pkg.sv
design/pip_ifaces.sv
design/pip_edge_test.sv
design/pip_poly_state.sv
design/point_in_polygon_test_unit.sv
verif/point_in_polygon_test_unit_tb.sv
